/* src/assert_macros.svh */
// Assertion helpers shared by the core and queue files of the frame splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

/* src/jmfs_pkg.sv */
// ----------------------------------------------------------------------------
// jmfs_pkg
// Shared constants and types of the JPEG marker frame splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jmfs_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int LEN_WIDTH   = 24;

    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    localparam logic [LEN_WIDTH-1:0] MAX_FRAME_RESET = LEN_WIDTH'(8 * 1024 * 1024);

    // Result queue sizing: one byte may produce two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   frame_first;
        logic                   frame_last;
        logic                   frame_abort;
        logic                   run_last;
        logic [COUNT_WIDTH-1:0] frames_total;
        logic [COUNT_WIDTH-1:0] dropped_total;
    } t_result;

    // Group of results handed from the core to the queue.
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

/* src/jmfs_core.sv */
// ----------------------------------------------------------------------------
// jmfs_core
// Marker tracking, frame length check and counters; one byte per cycle while i_take is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jmfs_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jmfs_pkg::LEN_WIDTH-1:0] i_cfg_data,
    input  logic                           i_take,
    input  logic [7:0]                     i_byte,
    output jmfs_pkg::t_push                o_push
);

    logic                             r_in_frame, n_in_frame;
    logic                             r_held, n_held;
    logic                             r_last_ff, n_last_ff;
    logic [jmfs_pkg::LEN_WIDTH-1:0]   r_frame_len, n_frame_len;
    logic [jmfs_pkg::COUNT_WIDTH-1:0] r_frames, n_frames;
    logic [jmfs_pkg::COUNT_WIDTH-1:0] r_dropped, n_dropped;
    logic [jmfs_pkg::LEN_WIDTH-1:0]   r_max_len;

    logic [jmfs_pkg::LEN_WIDTH:0]     next_len;
    logic [jmfs_pkg::LEN_WIDTH:0]     drop_add;
    logic [1:0]                       num;
    logic [7:0]                       byte0;
    logic                             first0, last0, abort0;

    assign next_len = {1'b0, r_frame_len} + (jmfs_pkg::LEN_WIDTH+1)'(1);

    always_comb begin
        n_in_frame  = r_in_frame;
        n_held      = r_held;
        n_last_ff   = r_last_ff;
        n_frame_len = r_frame_len;
        n_frames    = r_frames;
        drop_add    = '0;
        num         = 2'd0;
        byte0       = i_byte;
        first0      = 1'b0;
        last0       = 1'b0;
        abort0      = 1'b0;
        if (!r_in_frame) begin
            if (r_held) begin
                if (i_byte == jmfs_pkg::MARK_SOI) begin
                    num         = 2'd2;
                    byte0       = jmfs_pkg::MARK_FF;
                    first0      = 1'b1;
                    n_in_frame  = 1'b1;
                    n_held      = 1'b0;
                    n_last_ff   = 1'b0;
                    n_frame_len = jmfs_pkg::LEN_WIDTH'(2);
                end else if (i_byte == jmfs_pkg::MARK_FF) begin
                    drop_add = (jmfs_pkg::LEN_WIDTH+1)'(1);
                end else begin
                    drop_add = (jmfs_pkg::LEN_WIDTH+1)'(2);
                    n_held   = 1'b0;
                end
            end else if (i_byte == jmfs_pkg::MARK_FF) begin
                n_held = 1'b1;
            end else begin
                drop_add = (jmfs_pkg::LEN_WIDTH+1)'(1);
            end
        end else begin
            num = 2'd1;
            // The limit check wins over an end marker on the same byte.
            if (next_len > {1'b0, r_max_len}) begin
                abort0      = 1'b1;
                drop_add    = next_len;
                n_in_frame  = 1'b0;
                n_held      = 1'b0;
                n_last_ff   = 1'b0;
                n_frame_len = '0;
            end else if (r_last_ff && i_byte == jmfs_pkg::MARK_EOI) begin
                last0       = 1'b1;
                n_frames    = r_frames + jmfs_pkg::COUNT_WIDTH'(1);
                n_in_frame  = 1'b0;
                n_held      = 1'b0;
                n_last_ff   = 1'b0;
                n_frame_len = '0;
            end else begin
                n_frame_len = next_len[jmfs_pkg::LEN_WIDTH-1:0];
                n_last_ff   = (i_byte == jmfs_pkg::MARK_FF);
            end
        end
        n_dropped = r_dropped + jmfs_pkg::COUNT_WIDTH'(drop_add);
    end

    always_comb begin
        o_push.num                = i_take ? num : 2'd0;
        o_push.res0.out_byte      = byte0;
        o_push.res0.frame_first   = first0;
        o_push.res0.frame_last    = last0;
        o_push.res0.frame_abort   = abort0;
        o_push.res0.run_last      = (num == 2'd1);
        o_push.res0.frames_total  = n_frames;
        o_push.res0.dropped_total = n_dropped;
        o_push.res1.out_byte      = i_byte;
        o_push.res1.frame_first   = 1'b0;
        o_push.res1.frame_last    = 1'b0;
        o_push.res1.frame_abort   = 1'b0;
        o_push.res1.run_last      = 1'b1;
        o_push.res1.frames_total  = n_frames;
        o_push.res1.dropped_total = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_held      <= 1'b0;
            r_last_ff   <= 1'b0;
            r_frame_len <= '0;
            r_frames    <= '0;
            r_dropped   <= '0;
        end else if (i_take) begin
            r_in_frame  <= n_in_frame;
            r_held      <= n_held;
            r_last_ff   <= n_last_ff;
            r_frame_len <= n_frame_len;
            r_frames    <= n_frames;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= jmfs_pkg::MAX_FRAME_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    // An FF is only held back while hunting.
    `ASSERT_NEVER(a_held_in_frame, i_clk, i_rst_n, r_in_frame && r_held)
    // Hunting keeps no frame length and no pending FF flag.
    `ASSERT_ALWAYS(a_hunt_clean, i_clk, i_rst_n,
        !r_in_frame |-> (r_frame_len == '0 && !r_last_ff))

endmodule

/* src/jmfs_queue.sv */
// ----------------------------------------------------------------------------
// jmfs_queue
// Small result queue: takes up to two results per cycle, gives out one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jmfs_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  jmfs_pkg::t_push                i_push,
    input  logic                           i_pop,
    output logic                           o_room,
    output logic                           o_valid,
    output jmfs_pkg::t_result              o_head
);

    jmfs_pkg::t_result                r_mem [jmfs_pkg::QUEUE_DEPTH];
    logic [jmfs_pkg::PTR_WIDTH-1:0]   r_wr, r_rd;
    logic [jmfs_pkg::CNT_WIDTH-1:0]   r_count;
    logic [jmfs_pkg::PTR_WIDTH-1:0]   wr_next;
    logic                             pop_ok;

    assign wr_next = r_wr + jmfs_pkg::PTR_WIDTH'(1);
    assign pop_ok  = i_pop && (r_count != '0);
    // Room is judged on the registered count so that two results always fit.
    assign o_room  = (r_count <= jmfs_pkg::CNT_WIDTH'(jmfs_pkg::QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + jmfs_pkg::PTR_WIDTH'(i_push.num);
            r_rd    <= r_rd + jmfs_pkg::PTR_WIDTH'(pop_ok);
            r_count <= r_count + jmfs_pkg::CNT_WIDTH'(i_push.num)
                       - jmfs_pkg::CNT_WIDTH'(pop_ok);
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n,
        r_count <= jmfs_pkg::CNT_WIDTH'(jmfs_pkg::QUEUE_DEPTH))
    `ASSERT_NEVER(a_push_no_room, i_clk, i_rst_n, (i_push.num != 2'd0) && !o_room)

endmodule

/* src/jpeg_marker_frame_splitter_unit.sv */
// ----------------------------------------------------------------------------
// jpeg_marker_frame_splitter_unit
// Splits an MJPEG byte stream into tagged frames at FF D8 / FF D9 markers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_data_byte
//  output    out        o_out_valid / i_out_stall o_out_byte, flags, counters
//  config    in         i_cfg_we                  i_cfg_data (max_frame_bytes)
//
//  One byte per cycle is taken while o_in_stall is low; a start marker yields
//  two results, so a run of them is limited by the single result read out of
//  the four-entry queue. A byte is registered at input, its results in the queue.
//  Reset is synchronous and active low; the limit returns to 8388608 bytes.
//  A stall on the output fills the queue and then stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_marker_frame_splitter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [jmfs_pkg::LEN_WIDTH-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_frame_first,
    output logic                             o_frame_last,
    output logic                             o_frame_abort,
    output logic                             o_run_last,
    output logic [jmfs_pkg::COUNT_WIDTH-1:0] o_frames_total,
    output logic [jmfs_pkg::COUNT_WIDTH-1:0] o_dropped_total
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              room;
    logic              take;
    logic              in_xfer;
    jmfs_pkg::t_push   push;
    jmfs_pkg::t_result head;

    assign take       = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
        end
    end

    jmfs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_byte     (r_in_byte),
        .o_push     (push)
    );

    jmfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_out_byte      = head.out_byte;
    assign o_frame_first   = head.frame_first;
    assign o_frame_last    = head.frame_last;
    assign o_frame_abort   = head.frame_abort;
    assign o_run_last      = head.run_last;
    assign o_frames_total  = head.frames_total;
    assign o_dropped_total = head.dropped_total;

endmodule
